>>> hw/rtl/rpa_pkg.sv
// Shared constants, codes and transaction types of the page allocator.
package rpa_pkg;

  localparam int unsigned NUM_PAGES  = 1024;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned REF_BITS   = 8;

  localparam int unsigned ADDR_W     = 22;
  localparam int unsigned PAGE_BITS  = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [CNT_W-1:0]    FIRST_FREE_RESET = CNT_W'(64);
  localparam logic [CNT_W-1:0]    PAGE_LIMIT = CNT_W'(NUM_PAGES);

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes
  localparam cmd_t CMD_INIT   = 3'd0;
  localparam cmd_t CMD_ALLOC  = 3'd1;
  localparam cmd_t CMD_FREE   = 3'd2;
  localparam cmd_t CMD_ADDREF = 3'd3;
  localparam cmd_t CMD_GETREF = 3'd4;

  // Status codes
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_OOM       = 3'd1;
  localparam status_t ST_MISALIGN  = 3'd2;
  localparam status_t ST_RANGE     = 3'd3;
  localparam status_t ST_UNDERFLOW = 3'd4;
  localparam status_t ST_FULL      = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COW        = 1'd1;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] address;
  } rpa_in_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   page_address;
    logic [REF_BITS-1:0] ref_count;
    logic [CNT_W-1:0]    free_count;
    logic [CNT_W-1:0]    total_count;
  } rpa_out_t;

endpackage

>>> hw/rtl/rpa_ram.sv
// Simple dual-port synchronous RAM with registered read.
module rpa_ram #(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/refcounted_page_allocator.sv
// Top level: free page stack and reference count table around a command sequencer.
// Alloc, free, addref, getref: accepted in S_IDLE, result registered on leaving S_EXEC.
// A new command waits until the last leaves S_EXEC: each reads, then writes, the RAMs.
// Init: clears one count entry per cycle, and writes a stack entry while below total_c.
// Reset (synchronous, rst_n low): registers to defaults, then a pass over every page
// clears the count table with busy high. Results cannot be stalled by the receiver.
module refcounted_page_allocator import rpa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rpa_in_t               in_data,
  output logic                  out_valid,
  output rpa_out_t              out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_INIT} state_t;

  state_t                state_r;
  logic [PAGE_BITS-1:0]  sweep_r;
  logic [CNT_W-1:0]      depth_r;
  logic [CNT_W-1:0]      depth_nxt;
  logic [CNT_W-1:0]      first_free_r;
  logic                  cow_r;
  cmd_t                  cmd_r;
  logic [ADDR_W-1:0]     addr_r;
  rpa_out_t              out_r;
  rpa_out_t              res_nxt;
  logic                  out_valid_r;

  logic [CNT_W-1:0]      total_c;
  logic [CNT_W-1:0]      sweep_ext;
  logic [PAGE_BITS-1:0]  page;
  logic [CNT_W-1:0]      page_ext;
  logic                  sweep_last;

  logic                  stk_we;
  logic [PAGE_BITS-1:0]  stk_waddr;
  logic [PAGE_BITS-1:0]  stk_wdata;
  logic [PAGE_BITS-1:0]  stk_raddr;
  logic [PAGE_BITS-1:0]  stk_rdata;
  logic                  ref_we;
  logic [PAGE_BITS-1:0]  ref_waddr;
  logic [REF_BITS-1:0]   ref_wdata;
  logic [PAGE_BITS-1:0]  ref_raddr;
  logic [REF_BITS-1:0]   ref_rdata;

  rpa_ram #(.WIDTH(PAGE_BITS), .ADDR_BITS(PAGE_BITS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  rpa_ram #(.WIDTH(REF_BITS), .ADDR_BITS(PAGE_BITS)) u_refs (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  // Derive page counts and sweep position
  assign total_c    = (first_free_r >= PAGE_LIMIT) ? '0 : PAGE_LIMIT - first_free_r;
  assign sweep_ext  = CNT_W'(sweep_r);
  assign sweep_last = (sweep_r == PAGE_BITS'(NUM_PAGES - 1));
  assign page       = addr_r[ADDR_W-1:PAGE_SHIFT];
  assign page_ext   = CNT_W'(page);

  // Issue reads at acceptance: top of stack and the addressed count
  assign stk_raddr  = PAGE_BITS'(depth_r - CNT_W'(1));
  assign ref_raddr  = in_data.address[ADDR_W-1:PAGE_SHIFT];

  // Decode the command against the read data and drive the write ports
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = depth_r[PAGE_BITS-1:0];
    stk_wdata = page;
    ref_we    = 1'b0;
    ref_waddr = page;
    ref_wdata = '0;
    depth_nxt = depth_r;
    res_nxt   = '0;

    unique case (state_r)
      S_CLEAR: begin
        ref_we    = 1'b1;
        ref_waddr = sweep_r;
      end
      S_INIT: begin
        ref_we    = 1'b1;
        ref_waddr = sweep_r;
        stk_we    = (sweep_ext < total_c);
        stk_waddr = sweep_r;
        stk_wdata = PAGE_BITS'(first_free_r + sweep_ext);
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (depth_r == '0) begin
              res_nxt.status = ST_OOM;
            end else begin
              depth_nxt            = depth_r - CNT_W'(1);
              res_nxt.page_address = ADDR_W'({stk_rdata, {PAGE_SHIFT{1'b0}}});
              res_nxt.ref_count    = REF_BITS'(1);
              ref_we               = cow_r;
              ref_waddr            = stk_rdata;
              ref_wdata            = REF_BITS'(1);
            end
          end
          CMD_FREE: begin
            if (addr_r[PAGE_SHIFT-1:0] != '0) begin
              res_nxt.status = ST_MISALIGN;
            end else if (page_ext < first_free_r || page_ext >= PAGE_LIMIT) begin
              res_nxt.status = ST_RANGE;
            end else if (cow_r && ref_rdata == '0) begin
              res_nxt.status = ST_UNDERFLOW;
            end else begin
              if (cow_r) begin
                ref_we            = 1'b1;
                ref_wdata         = ref_rdata - REF_BITS'(1);
                res_nxt.ref_count = ref_rdata - REF_BITS'(1);
              end
              // Push once the last reference is gone, or on any free with copy-on-write off
              if (!cow_r || ref_rdata == REF_BITS'(1)) begin
                if (depth_r >= PAGE_LIMIT) begin
                  res_nxt.status = ST_FULL;
                end else begin
                  stk_we    = 1'b1;
                  depth_nxt = depth_r + CNT_W'(1);
                end
              end
            end
          end
          CMD_ADDREF: begin
            if (page_ext >= PAGE_LIMIT) begin
              res_nxt.status = ST_RANGE;
            end else if (cow_r) begin
              ref_we            = 1'b1;
              ref_wdata         = (ref_rdata == REF_MAX) ? ref_rdata : ref_rdata + REF_BITS'(1);
              res_nxt.ref_count = ref_wdata;
            end else begin
              res_nxt.ref_count = REF_BITS'(1);
            end
          end
          CMD_GETREF: begin
            if (page_ext >= PAGE_LIMIT) begin
              res_nxt.status = ST_RANGE;
            end else begin
              res_nxt.ref_count = cow_r ? ref_rdata : REF_BITS'(1);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res_nxt.free_count  = (state_r == S_INIT) ? total_c : depth_nxt;
    res_nxt.total_count = total_c;
  end

  // Sequencer: state, stack depth and the registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      sweep_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          sweep_r <= sweep_r + PAGE_BITS'(1);
          if (sweep_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r   <= in_data.cmd;
            addr_r  <= in_data.address;
            sweep_r <= '0;
            state_r <= (in_data.cmd == CMD_INIT) ? S_INIT : S_EXEC;
          end
        end
        S_EXEC: begin
          depth_r     <= depth_nxt;
          out_r       <= res_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_INIT: begin
          sweep_r <= sweep_r + PAGE_BITS'(1);
          if (sweep_last) begin
            depth_r     <= total_c;
            out_r       <= res_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_free_r <= FIRST_FREE_RESET;
      cow_r        <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIRST_FREE) begin
        first_free_r <= CNT_W'(cfg_wdata);
      end
      if (cfg_index == CFG_COW) begin
        cow_r <= cfg_wdata[0];
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> hw/rtl/rpa_checker.sv
// Port-level checks of the page allocator, bound to the top level.
module rpa_checker import rpa_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input rpa_in_t               in_data,
  input logic                  out_valid,
  input rpa_out_t              out_res,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // An accepted transaction occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // A result appears only once the block is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // Each transaction gives one strobe, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // Out of memory is reported only with an empty stack
  a_oom_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_OOM |-> out_res.free_count == '0)
    else $error("out of memory reported with pages on the stack");

  // The stack never holds more than the page count
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.free_count <= PAGE_LIMIT)
    else $error("free count above page limit");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);
